// ----- hdl/sdq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared constants, codes and types of the sorted double-ended queue.
// ----------------------------------------------------------------------------
package sdq_pkg;

    // sizing
    localparam int CAPACITY      = 64;
    localparam int KEY_WIDTH     = 64;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    // lowest-entry tree geometry
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // port field widths
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int KEY_PORT_W = 64;
    localparam int PAY_PORT_W = 32;
    localparam int CNT_PORT_W = 7;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP_HI = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_LO = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // command broadcast to the cell row
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_POP_HI,
        CMD_POP_LO
    } t_cmd;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DEC,
        S_UPD,
        S_LOW1,
        S_LOW2,
        S_RES
    } t_state;

    // contents of one cell
    typedef struct packed {
        logic                     valid;
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } t_cell_data;

    // control broadcast to every cell
    typedef struct packed {
        logic                     cmp_en;
        t_cmd                     cmd;
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ----- hdl/sdq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_cell
// One slot of the sorted row: holds an entry, compares it with the incoming
// key and shifts with its neighbors on insert and pop.
// ----------------------------------------------------------------------------
module sdq_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sdq_pkg::t_cell_ctrl i_ctrl,
    input  wire sdq_pkg::t_cell_data i_above,
    input  wire logic               i_above_gt,
    input  wire sdq_pkg::t_cell_data i_below,
    output sdq_pkg::t_cell_data     o_data,
    output logic                    o_gt,
    output logic                    o_eq,
    output logic                    o_last
);
    import sdq_pkg::*;

    logic                     r_valid, n_valid;
    logic [KEY_WIDTH-1:0]     r_key, n_key;
    logic [PAYLOAD_WIDTH-1:0] r_pay, n_pay;
    logic                     r_gt, r_eq;

    // next entry from the broadcast command
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_pay   = r_pay;
        case (i_ctrl.cmd)
            CMD_INSERT: begin
                if (!r_gt) begin
                    if (i_above_gt) begin
                        n_valid = 1'b1;
                        n_key   = i_ctrl.key;
                        n_pay   = i_ctrl.payload;
                    end else begin
                        n_valid = i_above.valid;
                        n_key   = i_above.key;
                        n_pay   = i_above.payload;
                    end
                end
            end
            CMD_POP_HI: begin
                n_valid = i_below.valid;
                n_key   = i_below.key;
                n_pay   = i_below.payload;
            end
            CMD_POP_LO: begin
                if (r_valid && !i_below.valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // entry storage and compare flags
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
        if (i_ctrl.cmp_en) begin
            r_gt <= r_valid && (r_key > i_ctrl.key);
            r_eq <= r_valid && (r_key == i_ctrl.key);
        end
    end

    assign o_data.valid   = r_valid;
    assign o_data.key     = r_key;
    assign o_data.payload = r_pay;
    assign o_gt           = r_gt;
    assign o_eq           = r_eq;
    assign o_last         = r_valid && !i_below.valid;

endmodule
`default_nettype wire

// ----- hdl/sdq_low_tree.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdq_low_tree
// Two-level registered select of the lowest stored entry, marked by the
// one cell whose lower neighbor is empty.
// ----------------------------------------------------------------------------
module sdq_low_tree (
    input  wire logic                              i_clk,
    input  wire logic [sdq_pkg::CAPACITY-1:0]      i_last,
    input  wire sdq_pkg::t_cell_data               i_cells [sdq_pkg::CAPACITY],
    output logic [sdq_pkg::KEY_WIDTH-1:0]          o_low_key,
    output logic [sdq_pkg::PAYLOAD_WIDTH-1:0]      o_low_payload
);
    import sdq_pkg::*;

    logic [KEY_WIDTH-1:0]     n_grp_key [NUM_GROUPS];
    logic [PAYLOAD_WIDTH-1:0] n_grp_pay [NUM_GROUPS];
    logic [KEY_WIDTH-1:0]     r_grp_key [NUM_GROUPS];
    logic [PAYLOAD_WIDTH-1:0] r_grp_pay [NUM_GROUPS];
    logic [KEY_WIDTH-1:0]     n_low_key, r_low_key;
    logic [PAYLOAD_WIDTH-1:0] n_low_pay, r_low_pay;

    // first level: and-or within each group of cells
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_grp_key[g] = '0;
            n_grp_pay[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < CAPACITY) begin
                    if (i_last[g * GROUP_SIZE + j]) begin
                        n_grp_key[g] = n_grp_key[g] | i_cells[g * GROUP_SIZE + j].key;
                        n_grp_pay[g] = n_grp_pay[g] | i_cells[g * GROUP_SIZE + j].payload;
                    end
                end
            end
        end
    end

    // second level: or across groups
    always_comb begin
        n_low_key = '0;
        n_low_pay = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_low_key = n_low_key | r_grp_key[g];
            n_low_pay = n_low_pay | r_grp_pay[g];
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        r_grp_key <= n_grp_key;
        r_grp_pay <= n_grp_pay;
        r_low_key <= n_low_key;
        r_low_pay <= n_low_pay;
    end

    assign o_low_key     = r_low_key;
    assign o_low_payload = r_low_pay;

endmodule
`default_nettype wire

// ----- hdl/sorted_double_ended_queue_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_double_ended_queue_top
// Bounded sorted store with insert, pop-highest and pop-lowest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries action, key, payload and
//   the duplicate-reject flag. Output channel (o_out_valid / i_out_ready)
//   carries status, popped entry, entry count and key span, one result per
//   input transfer.
//   Entries sit in a row of cells in descending key order, slot 0 highest.
//   An item is handled one at a time by a sequencer: compare in every cell,
//   decide, shift the row, then through the registered tree that finds the
//   lowest entry (S_LOW1, S_LOW2), then span and result formation.
//   A new item is taken only after the compare, decide, shift and
//   lowest-entry tree steps of the previous one, once the sequencer is idle.
//   The result sits in an output register, so the next item is taken while
//   a result waits; if the receiver stalls, the following item holds in its
//   last step until the output register is free.
//   Reset empties the store (cell valid bits cleared) and drops any pending
//   result; entry storage itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [sdq_pkg::ACTION_W-1:0]     i_action,
    input  wire logic [sdq_pkg::KEY_PORT_W-1:0]   i_key,
    input  wire logic [sdq_pkg::PAY_PORT_W-1:0]   i_payload,
    input  wire logic                             i_reject_duplicate,
    // output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [sdq_pkg::STATUS_W-1:0]          o_status,
    output logic [sdq_pkg::KEY_PORT_W-1:0]        o_popped_key,
    output logic [sdq_pkg::PAY_PORT_W-1:0]        o_popped_payload,
    output logic [sdq_pkg::CNT_PORT_W-1:0]        o_entry_count,
    output logic [sdq_pkg::KEY_PORT_W-1:0]        o_key_span
);
    import sdq_pkg::*;

    t_state                   r_state, n_state;

    // captured item
    logic [ACTION_W-1:0]      r_act;
    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_pay;
    logic                     r_rej;

    // decision and bookkeeping
    t_cmd                     r_cmd, n_cmd;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic [CNT_W-1:0]         r_count;
    logic [KEY_WIDTH-1:0]     r_pop_key;
    logic [PAYLOAD_WIDTH-1:0] r_pop_pay;

    // output register
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_out_status;
    logic [KEY_PORT_W-1:0]    r_out_pkey;
    logic [PAY_PORT_W-1:0]    r_out_ppay;
    logic [CNT_PORT_W-1:0]    r_out_count;
    logic [KEY_PORT_W-1:0]    r_out_span;

    // cell row wiring
    t_cell_ctrl               w_ctrl;
    t_cell_data               w_cells [CAPACITY];
    logic [CAPACITY-1:0]      w_gt;
    logic [CAPACITY-1:0]      w_eq;
    logic [CAPACITY-1:0]      w_last;
    logic [KEY_WIDTH-1:0]     w_low_key;
    logic [PAYLOAD_WIDTH-1:0] w_low_pay;

    logic                     w_in_xfer;
    logic                     w_out_free;
    logic                     w_cmp_en;
    logic                     w_upd_en;
    logic                     w_load_out;
    logic                     w_any_eq;
    logic                     w_full;
    logic                     w_empty;
    logic [KEY_WIDTH-1:0]     w_span;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_any_eq   = |w_eq;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CMP;
            S_CMP:   n_state = S_DEC;
            S_DEC:   n_state = S_UPD;
            S_UPD:   n_state = S_LOW1;
            S_LOW1:  n_state = S_LOW2;
            S_LOW2:  n_state = S_RES;
            S_RES:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_cmp_en   = 1'b0;
        w_upd_en   = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_CMP:   w_cmp_en   = 1'b1;
            S_UPD:   w_upd_en   = 1'b1;
            S_RES:   w_load_out = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // input capture, keys and payloads trimmed to the stored width
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_act <= i_action;
            r_key <= i_key[KEY_WIDTH-1:0];
            r_pay <= i_payload[PAYLOAD_WIDTH-1:0];
            r_rej <= i_reject_duplicate;
        end
    end

    // decide status and row command
    always_comb begin
        n_cmd    = CMD_NONE;
        n_status = ST_OK;
        case (r_act)
            ACT_INSERT: begin
                if (r_rej && w_any_eq) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cmd = CMD_INSERT;
                end
            end
            ACT_POP_HI: begin
                if (w_empty) n_status = ST_EMPTY;
                else n_cmd = CMD_POP_HI;
            end
            ACT_POP_LO: begin
                if (w_empty) n_status = ST_EMPTY;
                else n_cmd = CMD_POP_LO;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DEC) begin
            r_cmd    <= n_cmd;
            r_status <= n_status;
        end
    end

    // popped entry captured before the row shifts
    always_ff @(posedge i_clk) begin
        if (w_upd_en) begin
            case (r_cmd)
                CMD_POP_HI: begin
                    r_pop_key <= w_cells[0].key;
                    r_pop_pay <= w_cells[0].payload;
                end
                CMD_POP_LO: begin
                    r_pop_key <= w_low_key;
                    r_pop_pay <= w_low_pay;
                end
                default: begin
                    r_pop_key <= '0;
                    r_pop_pay <= '0;
                end
            endcase
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_upd_en) begin
            case (r_cmd)
                CMD_INSERT: r_count <= r_count + CNT_W'(1);
                CMD_POP_HI: r_count <= r_count - CNT_W'(1);
                CMD_POP_LO: r_count <= r_count - CNT_W'(1);
                default:    r_count <= r_count;
            endcase
        end
    end

    // control broadcast to the row
    always_comb begin
        w_ctrl.cmp_en  = w_cmp_en;
        w_ctrl.cmd     = w_upd_en ? r_cmd : CMD_NONE;
        w_ctrl.key     = r_key;
        w_ctrl.payload = r_pay;
    end

    // row of cells, slot 0 holds the highest key
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_cell_data w_above;
            t_cell_data w_below;
            logic       w_above_gt;

            if (gi == 0) begin : g_head
                assign w_above    = '0;
                assign w_above_gt = 1'b1;
            end else begin : g_body
                assign w_above    = w_cells[gi-1];
                assign w_above_gt = w_gt[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_below = '0;
            end else begin : g_next
                assign w_below = w_cells[gi+1];
            end

            sdq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_above    (w_above),
                .i_above_gt (w_above_gt),
                .i_below    (w_below),
                .o_data     (w_cells[gi]),
                .o_gt       (w_gt[gi]),
                .o_eq       (w_eq[gi]),
                .o_last     (w_last[gi])
            );
        end
    endgenerate

    // lowest entry finder
    sdq_low_tree u_low_tree (
        .i_clk         (i_clk),
        .i_last        (w_last),
        .i_cells       (w_cells),
        .o_low_key     (w_low_key),
        .o_low_payload (w_low_pay)
    );

    // span after the step
    assign w_span = w_empty ? '0 : (w_cells[0].key - w_low_key);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_pkey   <= KEY_PORT_W'(r_pop_key);
            r_out_ppay   <= PAY_PORT_W'(r_pop_pay);
            r_out_count  <= CNT_PORT_W'(r_count);
            r_out_span   <= KEY_PORT_W'(w_span);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_popped_key     = r_out_pkey;
    assign o_popped_payload = r_out_ppay;
    assign o_entry_count    = r_out_count;
    assign o_key_span       = r_out_span;

endmodule
`default_nettype wire

// ----- sim/sorted_double_ended_queue_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_double_ended_queue_checker
// Watches both channels of the sorted queue, keeps its own sorted store, works
// out the result of every input transfer and compares each output transfer
// field by field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic [sdq_pkg::ACTION_W-1:0]   i_action,
    input  wire logic [sdq_pkg::KEY_PORT_W-1:0] i_key,
    input  wire logic [sdq_pkg::PAY_PORT_W-1:0] i_payload,
    input  wire logic                           i_reject_duplicate,
    // output channel
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [sdq_pkg::STATUS_W-1:0]   i_status,
    input  wire logic [sdq_pkg::KEY_PORT_W-1:0] i_popped_key,
    input  wire logic [sdq_pkg::PAY_PORT_W-1:0] i_popped_payload,
    input  wire logic [sdq_pkg::CNT_PORT_W-1:0] i_entry_count,
    input  wire logic [sdq_pkg::KEY_PORT_W-1:0] i_key_span,
    // verdict and statistics
    output int                                  o_fail_count,
    output int                                  o_pending_count,
    output int                                  o_dup_hits,
    output int                                  o_full_hits,
    output int                                  o_empty_hits
);
    import sdq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [KEY_PORT_W-1:0] popped_key;
        logic [PAY_PORT_W-1:0] popped_payload;
        logic [CNT_PORT_W-1:0] entry_count;
        logic [KEY_PORT_W-1:0] key_span;
    } t_queue_result;

    // shadow store, descending keys, slot 0 highest
    logic [KEY_WIDTH-1:0]     held_keys     [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] held_payloads [CAPACITY];
    int                       held_count = 0;

    t_queue_result expected_results [$];
    int mismatch_total = 0;
    int result_index   = 0;
    int dup_total      = 0;
    int full_total     = 0;
    int empty_total    = 0;

    // one line per mismatch, always counted
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] result %0d: %s got %h want %h",
                 $time, result_index, field, got, want);
        mismatch_total++;
    endtask

    // apply one operation to the shadow store and form its result
    task automatic apply_queue_op(input logic [ACTION_W-1:0] act,
                                  input logic [KEY_PORT_W-1:0] key,
                                  input logic [PAY_PORT_W-1:0] pay,
                                  input logic reject,
                                  output t_queue_result res);
        int slot;
        int i;
        res = '0;
        res.status = ST_OK;
        case (act)
            ACT_INSERT: begin
                slot = 0;
                while (slot < held_count && held_keys[slot] > key)
                    slot++;
                if (reject && slot < held_count && held_keys[slot] == key) begin
                    res.status = ST_DUP;
                end else if (held_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = held_count; i > slot; i--) begin
                        held_keys[i]     = held_keys[i-1];
                        held_payloads[i] = held_payloads[i-1];
                    end
                    held_keys[slot]     = key;
                    held_payloads[slot] = pay;
                    held_count++;
                end
            end
            ACT_POP_HI: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped_key     = held_keys[0];
                    res.popped_payload = held_payloads[0];
                    for (i = 1; i < held_count; i++) begin
                        held_keys[i-1]     = held_keys[i];
                        held_payloads[i-1] = held_payloads[i];
                    end
                    held_count--;
                end
            end
            ACT_POP_LO: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped_key     = held_keys[held_count-1];
                    res.popped_payload = held_payloads[held_count-1];
                    held_count--;
                end
            end
            default: ;  // no-op only reports count and span
        endcase
        res.entry_count = CNT_PORT_W'(held_count);
        if (held_count != 0)
            res.key_span = held_keys[0] - held_keys[held_count-1];
    endtask

    // compare the leaving result first, then predict the arriving item
    always @(posedge i_clk) begin : watch_channels
        t_queue_result got;
        t_queue_result want;
        if (!i_rst_n) begin
            held_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_status, i_popped_key, i_popped_payload, i_entry_count, i_key_span};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", 64'(got.status), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.popped_key !== want.popped_key)
                        report_mismatch("popped_key", got.popped_key, want.popped_key);
                    if (got.popped_payload !== want.popped_payload)
                        report_mismatch("popped_payload", 64'(got.popped_payload),
                                        64'(want.popped_payload));
                    if (got.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(got.entry_count),
                                        64'(want.entry_count));
                    if (got.key_span !== want.key_span)
                        report_mismatch("key_span", got.key_span, want.key_span);
                end
                result_index++;
            end
            if (i_in_valid && i_in_ready) begin
                apply_queue_op(i_action, i_key, i_payload, i_reject_duplicate, want);
                case (want.status)
                    ST_DUP:   dup_total++;
                    ST_FULL:  full_total++;
                    ST_EMPTY: empty_total++;
                    default:  ;
                endcase
                expected_results.push_back(want);
            end
        end
        o_fail_count    <= mismatch_total;
        o_pending_count <= expected_results.size();
        o_dup_hits      <= dup_total;
        o_full_hits     <= full_total;
        o_empty_hits    <= empty_total;
    end

endmodule

// ----- sim/sorted_double_ended_queue_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_double_ended_queue_top_tb
// Directed corner cases, then bursts of fill, drain and mixed traffic with
// random idling on both channels; the checker beside the block predicts every
// result and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue_top_tb;
    import sdq_pkg::*;

    localparam int RANDOM_ITEMS  = 930;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int IDLE_PCT      = 36;
    localparam int SETTLE_CYCLES = 20;

    typedef enum logic [1:0] {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED
    } t_burst;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [ACTION_W-1:0]   action     = ACT_NOP;
    logic [KEY_PORT_W-1:0] key        = '0;
    logic [PAY_PORT_W-1:0] payload    = '0;
    logic                  reject_dup = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [KEY_PORT_W-1:0] popped_key;
    logic [PAY_PORT_W-1:0] popped_payload;
    logic [CNT_PORT_W-1:0] entry_count;
    logic [KEY_PORT_W-1:0] key_span;

    logic gaps_on     = 1'b1;
    int   cycle_count = 0;
    int   fail_count;
    int   pending_count;
    int   dup_hits;
    int   full_hits;
    int   empty_hits;
    int   insert_sent = 0;
    int   pop_hi_sent = 0;
    int   pop_lo_sent = 0;
    int   nop_sent    = 0;

    sorted_double_ended_queue_top i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_action           (action),
        .i_key              (key),
        .i_payload          (payload),
        .i_reject_duplicate (reject_dup),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_status           (status),
        .o_popped_key       (popped_key),
        .o_popped_payload   (popped_payload),
        .o_entry_count      (entry_count),
        .o_key_span         (key_span)
    );

    sorted_double_ended_queue_checker i_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_action           (action),
        .i_key              (key),
        .i_payload          (payload),
        .i_reject_duplicate (reject_dup),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_status           (status),
        .i_popped_key       (popped_key),
        .i_popped_payload   (popped_payload),
        .i_entry_count      (entry_count),
        .i_key_span         (key_span),
        .o_fail_count       (fail_count),
        .o_pending_count    (pending_count),
        .o_dup_hits         (dup_hits),
        .o_full_hits        (full_hits),
        .o_empty_hits       (empty_hits)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random while gaps are enabled
    always @(posedge clk) begin
        out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // present one item, with random idle cycles ahead of it, until it transfers
    task automatic offer_item(input logic [ACTION_W-1:0] act,
                              input logic [KEY_PORT_W-1:0] k,
                              input logic [PAY_PORT_W-1:0] pay,
                              input logic rej);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        key        <= k;
        payload    <= pay;
        reject_dup <= rej;
        do @(posedge clk); while (!in_ready);
        case (act)
            ACT_INSERT: insert_sent++;
            ACT_POP_HI: pop_hi_sent++;
            ACT_POP_LO: pop_lo_sent++;
            default:    nop_sent++;
        endcase
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // keys cluster on a few values so duplicates and extremes are common
    function automatic logic [KEY_PORT_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            case ($urandom_range(0, 7))
                0:       return 64'h0000_0000_0000_0000;
                1:       return 64'h0000_0000_0000_0001;
                2:       return 64'h0000_0000_0000_0002;
                3:       return 64'h0000_0000_0000_0003;
                4:       return 64'hFFFF_FFFF_FFFF_FFFF;
                5:       return 64'hFFFF_FFFF_FFFF_FFFE;
                6:       return 64'h8000_0000_0000_0000;
                default: return 64'h7FFF_FFFF_FFFF_FFFF;
            endcase
        end
        if (r < 42)
            return KEY_PORT_W'($urandom_range(0, 255));
        if (r < 48)
            return {32'hFFFF_FFFF, 32'($urandom)};
        return {32'($urandom), 32'($urandom)};
    endfunction

    // action mix leans toward inserts or pops depending on the burst
    function automatic logic [ACTION_W-1:0] pick_action(input t_burst mode);
        int r;
        int insert_pct;
        case (mode)
            BURST_FILL:  insert_pct = 86;
            BURST_DRAIN: insert_pct = 8;
            default:     insert_pct = 46;
        endcase
        r = $urandom_range(0, 99);
        if (r < 3)
            return ACT_NOP;
        if (r < 3 + insert_pct)
            return ACT_INSERT;
        return ($urandom_range(0, 1) != 0) ? ACT_POP_HI : ACT_POP_LO;
    endfunction

    initial begin : stimulus
        int     random_sent;
        int     burst_len;
        int     n;
        t_burst mode;

        random_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store: both pops and the no-op
        offer_item(ACT_POP_HI, '1, '1, 1'b1);
        offer_item(ACT_POP_LO, '1, '1, 1'b0);
        offer_item(ACT_NOP,    '1, '1, 1'b1);
        // extreme keys, duplicate rejected and duplicate placed above equals
        offer_item(ACT_INSERT, 64'h0, 32'h0, 1'b1);
        offer_item(ACT_INSERT, '1, 32'hFFFF_FFFF, 1'b1);
        offer_item(ACT_INSERT, '1, 32'h1234_5678, 1'b1);
        offer_item(ACT_INSERT, '1, 32'hA5A5_A5A5, 1'b0);
        offer_item(ACT_INSERT, 64'h0, 32'h5A5A_5A5A, 1'b1);
        offer_item(ACT_INSERT, 64'h0, 32'h0000_0001, 1'b0);
        offer_item(ACT_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1);
        offer_item(ACT_NOP, 64'h0, 32'h0, 1'b0);
        // drain from both ends, equal keys come out newest first from the top
        offer_item(ACT_POP_HI, 64'h0, 32'h0, 1'b0);
        offer_item(ACT_POP_HI, 64'h0, 32'h0, 1'b0);
        offer_item(ACT_POP_LO, 64'h0, 32'h0, 1'b0);
        offer_item(ACT_POP_LO, 64'h0, 32'h0, 1'b0);
        offer_item(ACT_POP_LO, 64'h0, 32'h0, 1'b0);
        offer_item(ACT_POP_HI, 64'h0, 32'h0, 1'b0);
        offer_item(ACT_INSERT, 64'h1, 32'h0000_0011, 1'b1);
        offer_item(ACT_INSERT, 64'h2, 32'h0000_0022, 1'b1);
        offer_item(ACT_POP_LO, '1, '1, 1'b1);
        offer_item(ACT_POP_LO, '1, '1, 1'b1);
        wait_until_drained();

        // bursts: fill past capacity, drain past empty, or mixed churn
        while (random_sent < RANDOM_ITEMS) begin
            gaps_on <= !(random_sent >= 300 && random_sent < 520);
            case ($urandom_range(0, 3))
                0:       mode = BURST_FILL;
                1:       mode = BURST_DRAIN;
                default: mode = BURST_MIXED;
            endcase
            burst_len = (mode == BURST_MIXED) ? $urandom_range(15, 40)
                                              : $urandom_range(90, 110);
            for (n = 0; n < burst_len && random_sent < RANDOM_ITEMS; n++) begin
                offer_item(pick_action(mode), pick_key(), 32'($urandom),
                           1'($urandom_range(0, 1)));
                random_sent++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_until_drained();
        end

        // let the last results come back, then settle
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d transfers: %0d inserts, %0d high pops, %0d low pops, %0d no-ops",
                 insert_sent + pop_hi_sent + pop_lo_sent + nop_sent,
                 insert_sent, pop_hi_sent, pop_lo_sent, nop_sent);
        $display("rejects seen: %0d duplicate, %0d full store, %0d pops on empty",
                 dup_hits, full_hits, empty_hits);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
